### src/acia_receive_register_model_macros.svh
// ---------------------------------------------------------------------------
// ACIA receive register model - assertion macros
// Concurrent check helpers, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef ACIA_RECEIVE_REGISTER_MODEL_MACROS_SVH
`define ACIA_RECEIVE_REGISTER_MODEL_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define ACIA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ACIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ACIA_ASSERT_SAME(lbl, ante, cons, msg)
`define ACIA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### src/acia_pkg.sv
// ---------------------------------------------------------------------------
// ACIA package
// Request codes, register fields and beat layouts for the receive model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acia_pkg;

  // request kinds
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // register select
  localparam logic SEL_CTRL = 1'b0;
  localparam logic SEL_DATA = 1'b1;

  // status / control bits
  localparam logic [7:0] STAT_TDRE       = 8'h02;
  localparam logic [7:0] STAT_RDRF       = 8'h01;
  localparam logic [1:0] CTRL_RESET_CODE = 2'b11;
  localparam int         CTRL_IRQ_BIT    = 7;
  localparam logic [1:0] CTRL_RTS_OFF    = 2'b10;

  localparam logic [15:0] BYTE_GAP_RESET = 16'd64;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic       reg_select;
    logic [1:0] req_type;
  } in_user_t;

  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] write_data;
  } in_data_t;

  typedef struct packed {
    logic [3:0] pad;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       rx_pop;
    logic       rts;
    logic       irq;
    logic [7:0] read_data;
  } out_data_t;

endpackage

`default_nettype wire

### src/acia_receive_register_model.sv
// ---------------------------------------------------------------------------
// ACIA receive register model - top level
// Serial port register block with a one-byte receive holding register.
// ---------------------------------------------------------------------------
// One bus access or tick enters per beat and one result beat leaves for each.
// A new beat is taken every cycle unless the result sink stalls; each beat
// passes the input register, then the result register, where the state
// update and the result are computed together by a short flag and 16-bit
// decrement path. If the result sink stalls, one more beat is held in the
// input register before s_tready drops. byte_gap resets to 64; the user must
// write it through cfg_we / cfg_wdata only while no beat is in flight (the block does not enforce this).
`timescale 1ns / 1ps
`default_nettype none

`include "acia_receive_register_model_macros.svh"

module acia_receive_register_model (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config: byte_gap
  input  wire logic                             cfg_we,
  input  wire logic [15:0]                      cfg_wdata,
  // input beats
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [7:0] write_data, [8] rx_valid, [16:9] rx_byte, [23:17] zero
  input  wire logic [acia_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] req_type, [2] reg_select
  input  wire logic [acia_pkg::IN_USER_W-1:0]   s_tuser,
  // result beats
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [7:0] read_data, [8] irq, [9] rts, [10] rx_pop, [11] tx_valid,
  // [19:12] tx_byte, [23:20] zero
  output logic [acia_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import acia_pkg::*;

  // config and architectural state
  logic [15:0] byte_gap;
  logic [7:0]  holding_byte;
  logic        holding_full;
  logic        rx_irq_enable;
  logic        rts_on;
  logic [15:0] gap_count;

  // input register
  logic      in_vld;
  in_data_t  in_data;
  in_user_t  in_user;

  // result register
  logic      out_vld;
  out_data_t out_data;

  // next values
  logic [7:0]  holding_byte_next;
  logic        holding_full_next;
  logic        rx_irq_enable_next;
  logic        rts_on_next;
  logic [15:0] gap_count_next;
  logic [15:0] gap_dec;
  out_data_t   result_next;

  logic adv;

  // input stage moves to the result register when that slot is free or drains
  assign adv      = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || adv;
  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;

  assign gap_dec = (gap_count != 16'd0) ? gap_count - 16'd1 : 16'd0;

  always_comb begin
    holding_byte_next  = holding_byte;
    holding_full_next  = holding_full;
    rx_irq_enable_next = rx_irq_enable;
    rts_on_next        = rts_on;
    gap_count_next     = gap_count;
    result_next        = '0;

    unique case (in_user.req_type)
      REQ_TICK: begin
        gap_count_next = gap_dec;
        // latch once the gap ran out, RTS is up, the holding reg is free and a byte is offered
        if (!holding_full && rts_on && gap_dec == 16'd0 && in_data.rx_valid) begin
          holding_byte_next = in_data.rx_byte;
          holding_full_next = 1'b1;
        end
      end
      REQ_READ: begin
        if (in_user.reg_select == SEL_CTRL) begin
          result_next.read_data = STAT_TDRE | (holding_full ? STAT_RDRF : 8'h00);
        end else begin
          result_next.read_data = holding_byte;
          if (holding_full) begin
            holding_full_next  = 1'b0;
            result_next.rx_pop = 1'b1;
            gap_count_next     = byte_gap;
          end
        end
      end
      REQ_WRITE: begin
        if (in_user.reg_select == SEL_DATA) begin
          result_next.tx_valid = 1'b1;
          result_next.tx_byte  = in_data.write_data;
        end else if (in_data.write_data[1:0] == CTRL_RESET_CODE) begin
          // master reset: the unread byte stays at the source
          holding_full_next  = 1'b0;
          rx_irq_enable_next = 1'b0;
          rts_on_next        = 1'b0;
        end else begin
          rx_irq_enable_next = in_data.write_data[CTRL_IRQ_BIT];
          rts_on_next        = (in_data.write_data[6:5] != CTRL_RTS_OFF);
        end
      end
      default: begin
        // unused request code: no state change
      end
    endcase

    result_next.irq = holding_full_next && rx_irq_enable_next;
    result_next.rts = rts_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gap      <= BYTE_GAP_RESET;
      holding_byte  <= 8'h00;
      holding_full  <= 1'b0;
      rx_irq_enable <= 1'b0;
      rts_on        <= 1'b1;
      gap_count     <= 16'd0;
      in_vld        <= 1'b0;
      out_vld       <= 1'b0;
    end else begin
      if (cfg_we) begin
        byte_gap <= cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        in_vld <= 1'b1;
      end else if (adv) begin
        in_vld <= 1'b0;
      end
      if (adv) begin
        out_vld       <= 1'b1;
        holding_byte  <= holding_byte_next;
        holding_full  <= holding_full_next;
        rx_irq_enable <= rx_irq_enable_next;
        rts_on        <= rts_on_next;
        gap_count     <= gap_count_next;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= in_data_t'(s_tdata);
      in_user <= in_user_t'(s_tuser);
    end
    if (adv) begin
      out_data <= result_next;
    end
  end

  `ACIA_ASSERT_NEXT(a_irq_tracks_state, adv, out_data.irq == (holding_full && rx_irq_enable), "irq result does not match state")
  `ACIA_ASSERT_NEXT(a_pop_clears_full, adv, !out_data.rx_pop || !holding_full, "pop left holding register full")
  `ACIA_ASSERT_NEXT(a_pop_needs_full, adv && !holding_full, !out_data.rx_pop, "pop without a held byte")
  `ACIA_ASSERT_NEXT(a_pop_loads_gap, adv && result_next.rx_pop, gap_count == byte_gap, "gap not restarted on pop")
  `ACIA_ASSERT_SAME(a_tx_only_on_write, out_vld && !out_data.tx_valid, out_data.tx_byte == 8'h00, "tx byte set without tx valid")

endmodule

`default_nettype wire
